// File: rtl/core/sog_pkg.sv
// Package for the sine oscillator with glide: sequencer states, divider status,
// fixed-point widths, reset values and the sine table entry function.
// No dependencies; every module of the block imports it.
`default_nettype none

package sog_pkg;

	localparam int FREQ_W  = 29;
	localparam int INC_W   = 30;
	localparam int VOL_W   = 16;
	localparam int LEN_W   = 13;
	localparam int SCALE_W = 36;
	localparam int PHASE_W = 32;
	localparam int SMP_W   = 16;
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 19;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SCALE_LO_W = 18;
	localparam int DIV_CNT_W  = 5;

	localparam logic [FREQ_W-1:0]  FREQ_RESET  = 29'd32768000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd5864062014;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FREQ,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Sine of a 32-bit phase in Q1.15, from a Q30 Taylor series on the first quadrant.
	function automatic logic signed [SMP_W-1:0] sine_from_t(input logic [31:0] t);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] v;
		logic [SMP_W-1:0] mag;
		r = {34'd0, t[29:0]};
		if (t[30]) begin
			r = 64'h4000_0000 - r;
		end
		x = (r * HALF_PI_Q30) >> 30;
		sum = x;
		term = x;
		for (int n = 1; n <= 6; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TAYLOR_DIV[n-1];
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		mag = v[SMP_W-1:0];
		return t[31] ? $signed(16'd0 - mag) : $signed(mag);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sog_rom.sv
// Sine table with a registered read port, one entry per table index.
// Depends on sog_pkg for the entry function.
`default_nettype none

module sog_rom
	import sog_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic [$clog2(DEPTH)-1:0]       addr,
	output logic signed [SMP_W-1:0]             data_q
);

	logic signed [SMP_W-1:0] tbl [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam logic [31:0] T_K = 32'((64'(k) << 32) / DEPTH);
		assign tbl[k] = sine_from_t(T_K);
	end

	always_ff @(posedge clk) begin
		data_q <= tbl[addr];
	end

endmodule

`default_nettype wire

// File: rtl/core/sog_mul.sv
// Shared signed multiplier with a registered product.
// Depends on sog_pkg for operand widths.
`default_nettype none

module sog_mul
	import sog_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

`default_nettype wire

// File: rtl/core/sog_div.sv
// Serial restoring divider, one quotient bit per cycle, for the glide increment.
// Depends on sog_pkg for widths and the status struct.
`default_nettype none

module sog_div
	import sog_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FREQ_W-1:0] dividend,
	input  wire logic [LEN_W-1:0]  divisor,
	output div_stat_t              stat,
	output logic [FREQ_W-1:0]      quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     dsr_q;
	logic [LEN_W-1:0]     rem_q;
	logic [FREQ_W-1:0]    quo_q;
	logic [LEN_W:0]       rem_sh;
	logic [LEN_W:0]       rem_sub;
	logic                 fits;

	assign rem_sh  = {rem_q, quo_q[FREQ_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign fits    = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(FREQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
			quo_q <= {quo_q[FREQ_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/sine_oscillator_with_glide.sv
// Top level of the sine oscillator with linear frequency glide.
// Depends on sog_pkg, sog_rom, sog_mul and sog_div.
//
// Each input item is one sample tick and yields one output sample. A new item is
// accepted only in ST_IDLE. With no division needed, an item runs through ST_FREQ,
// the frequency update, which also starts the gain product; ST_MUL_LO and ST_MUL_HI,
// the low and high halves of the frequency-to-phase-step product; and ST_DONE, the
// load of the output register. The first tick of a block whose target differs from
// the current frequency passes through ST_DIV first, which waits for the serial
// divider and then loads the increment. ST_DONE also waits while the previous
// sample has not been taken from the output register.
`default_nettype none

module sine_oscillator_with_glide
	import sog_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int MAX_BLOCK_LEN    = 4096
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [FREQ_W-1:0]       target_freq,
	input  wire logic [VOL_W-1:0]        volume,
	input  wire logic [LEN_W-1:0]        block_len,
	input  wire logic                    first_in_block,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [SMP_W-1:0]      sample_out,
	input  wire logic                    cfg_we,
	input  wire logic [SCALE_W-1:0]      cfg_wdata
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

	state_t state_q, state_d;

	logic [SCALE_W-1:0]      scale_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [FREQ_W-1:0]       cur_q;
	logic [INC_W-1:0]        inc_q;
	logic [LEN_W-1:0]        ticks_q;
	logic [FREQ_W-1:0]       tgt_q;
	logic [VOL_W-1:0]        vol_q;
	logic                    neg_q;
	logic signed [SMP_W-1:0] res_q;
	logic [46:0]             plo_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] sample_q;

	logic                    accept;
	logic                    out_free;
	logic                    div_start;
	logic                    same_freq;
	logic [LEN_W-1:0]        len_clamped;
	logic [INC_W-1:0]        diff;
	logic [FREQ_W-1:0]       diff_mag;
	logic [63:0]             idx_prod;
	logic [IDX_W-1:0]        rom_addr;
	logic signed [SMP_W-1:0] rom_data;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	div_stat_t               div_stat;
	logic [FREQ_W-1:0]       div_quo;
	logic [30:0]             f_sum;
	logic [LEN_W-1:0]        ticks_dec;
	logic [33:0]             rnd_sum;
	logic [18:0]             rnd_sh;
	logic signed [SMP_W-1:0] res_sat;
	logic [47:0]             step_sum;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		len_clamped = block_len;
		if (block_len == '0) begin
			len_clamped = LEN_W'(1);
		end else if ({1'b0, block_len} > (LEN_W + 1)'(MAX_BLOCK_LEN)) begin
			len_clamped = LEN_W'(MAX_BLOCK_LEN);
		end
	end

	assign same_freq = target_freq == cur_q;
	assign diff      = {1'b0, target_freq} - {1'b0, cur_q};
	assign diff_mag  = diff[INC_W-1] ? FREQ_W'(INC_W'(0) - diff) : diff[FREQ_W-1:0];

	assign idx_prod = 64'(phase_q) * 64'(SINE_TABLE_DEPTH);
	assign rom_addr = idx_prod[PHASE_W +: IDX_W];

	assign f_sum     = {2'b00, cur_q} + {inc_q[INC_W-1], inc_q};
	assign ticks_dec = ticks_q - 1'b1;

	assign rnd_sum = mul_p[33:0] + 34'd16384;
	assign rnd_sh  = rnd_sum[33:15];
	always_comb begin
		if ($signed(rnd_sh) > 19'sd32767) begin
			res_sat = 16'sh7fff;
		end else if ($signed(rnd_sh) < -19'sd32768) begin
			res_sat = -16'sh8000;
		end else begin
			res_sat = $signed(rnd_sh[SMP_W-1:0]);
		end
	end

	assign step_sum = 48'(mul_p[46:0]) + 48'(plo_q[46:SCALE_LO_W]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (first_in_block && !same_freq) ? ST_DIV : ST_FREQ;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_FREQ;
				end
			end
			ST_FREQ:   state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q) inside
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && first_in_block && !same_freq;
			end
			ST_FREQ: begin
				mul_a = $signed({14'd0, vol_q});
				mul_b = $signed({{(MUL_B_W - SMP_W){rom_data[SMP_W-1]}}, rom_data});
			end
			ST_MUL_LO: begin
				mul_a = $signed({1'b0, cur_q});
				mul_b = $signed({1'b0, scale_q[SCALE_LO_W-1:0]});
			end
			ST_MUL_HI, ST_DONE: begin
				mul_a = $signed({1'b0, cur_q});
				mul_b = $signed({1'b0, scale_q[SCALE_W-1:SCALE_LO_W]});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= SCALE_RESET;
			phase_q     <= '0;
			cur_q       <= FREQ_RESET;
			inc_q       <= '0;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && first_in_block) begin
						ticks_q <= len_clamped;
						if (same_freq) begin
							inc_q <= '0;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						inc_q <= neg_q ? (INC_W'(0) - {1'b0, div_quo}) : {1'b0, div_quo};
					end
				end
				ST_FREQ: begin
					if (ticks_q != '0) begin
						ticks_q <= ticks_dec;
						if (ticks_dec == '0) begin
							cur_q <= tgt_q;
						end else if (f_sum[30]) begin
							cur_q <= '0;
						end else begin
							cur_q <= f_sum[FREQ_W-1:0];
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						phase_q <= phase_q + step_sum[45:14];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q <= target_freq;
			vol_q <= volume;
			neg_q <= diff[INC_W-1];
		end
		if (state_q == ST_MUL_LO) begin
			res_q <= res_sat;
		end
		if (state_q == ST_MUL_HI) begin
			plo_q <= mul_p[46:0];
		end
		if (state_q == ST_DONE && out_free) begin
			sample_q <= res_q;
		end
	end

	sog_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.addr  (rom_addr),
		.data_q(rom_data)
	);

	sog_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(mul_p)
	);

	sog_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(diff_mag),
		.divisor (len_clamped),
		.stat    (div_stat),
		.quotient(div_quo)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

endmodule

`default_nettype wire

// File: bench/tb_sine_oscillator_with_glide.sv
// Self-checking testbench for sine_oscillator_with_glide: a table of directed ticks,
// then random glide blocks over several step-scale settings, each sample checked
// against a fixed value or an in-bench glide and DDS model. Depends on sog_pkg, RTL.
`timescale 1ns / 100ps

module tb_sine_oscillator_with_glide
	import sog_pkg::*;
();

	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_LEN_CLAMP = 4096;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [SCALE_W-1:0] SCALE_MIN = 36'd1466015503;
	localparam logic [SCALE_W-1:0] SCALE_MAX = 36'd35184372088;
	localparam logic [SCALE_W-1:0] SCALE_ONES = '1;
	localparam int N_ROWS = 22;
	localparam int N_PHASES = 5;
	localparam int TICKS_PER_PHASE = 340;
	localparam int SETTLE_CYCLES = 48;

	typedef struct packed {
		logic [FREQ_W-1:0] target;
		logic [VOL_W-1:0] vol;
		logic [LEN_W-1:0] len;
		logic first;
		logic fixed;
		logic signed [SMP_W-1:0] want;
	} tick_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [FREQ_W-1:0] target_freq;
	logic [VOL_W-1:0] volume;
	logic [LEN_W-1:0] block_len;
	logic first_in_block;
	logic out_valid;
	logic out_ready;
	logic signed [SMP_W-1:0] sample_out;
	logic cfg_we;
	logic [SCALE_W-1:0] cfg_wdata;

	int sine_lut [TABLE_DEPTH];
	logic [PHASE_W-1:0] osc_phase;
	logic [FREQ_W-1:0] osc_freq;
	longint glide_step;
	int glide_left;
	logic [SCALE_W-1:0] scale_now;

	logic signed [SMP_W-1:0] sample_q [$];
	int mismatches;
	int ticks_sent;
	int blocks_started;
	int samples_checked;
	int scales_used;
	int tx_odds;
	int rx_odds;
	bit no_idle;
	bit long_hold;

	tick_row_t dir_rows [N_ROWS] = '{
		'{32768000, 32768, 1, 0, 1, 0},
		'{65536000, 0, 4, 1, 1, 0},
		'{65536000, 65535, 4, 0, 0, 0},
		'{65536000, 32768, 4, 0, 0, 0},
		'{98304000, 32768, 4, 0, 0, 0},
		'{98304000, 32768, 9, 1, 0, 0},
		'{98304000, 32768, 9, 0, 0, 0},
		'{32768000, 40000, 3, 1, 0, 0},
		'{32768000, 40000, 3, 0, 0, 0},
		'{3276800, 32768, 0, 1, 0, 0},
		'{327680000, 65535, 8191, 1, 0, 0},
		'{327680000, 32768, 0, 0, 0, 0},
		'{327680000, 32768, 0, 0, 0, 0},
		'{327680000, 32768, 4096, 1, 0, 0},
		'{327680000, 32767, 4096, 0, 0, 0},
		'{536870911, 65535, 1, 1, 0, 0},
		'{0, 32768, 2, 1, 0, 0},
		'{0, 32768, 2, 0, 0, 0},
		'{12345678, 32768, 5, 0, 0, 0},
		'{3276800, 1, 1, 1, 0, 0},
		'{200000000, 65535, 6, 1, 0, 0},
		'{200000000, 32768, 6, 0, 0, 0}
	};

	sine_oscillator_with_glide #(
		.SINE_TABLE_DEPTH(TABLE_DEPTH),
		.MAX_BLOCK_LEN(MAX_LEN_CLAMP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_freq(target_freq),
		.volume(volume),
		.block_len(block_len),
		.first_in_block(first_in_block),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	function automatic int sine_point(input int k);
		longint unsigned r;
		longint unsigned x;
		longint unsigned acc;
		longint unsigned term;
		longint unsigned mag;
		int quad;
		quad = k >> 8;
		r = longint'(k & 255) << 22;
		if (quad[0]) begin
			r = 64'h4000_0000 - r;
		end
		x = (r * QUARTER_TURN_Q30) >> 30;
		acc = x;
		term = x;
		for (int n = 1; n <= 6; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		mag = (acc + 64'd16384) >> 15;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return (quad >= 2) ? -int'(mag) : int'(mag);
	endfunction

	function automatic logic [PHASE_W-1:0] freq_to_step(input logic [FREQ_W-1:0] f,
			input logic [SCALE_W-1:0] s);
		logic [95:0] p;
		p = 96'(f) * 96'(s);
		return p[63:32];
	endfunction

	// Advances the glide and phase state by one tick and returns the sample it yields.
	function automatic logic signed [SMP_W-1:0] next_sample(input logic [FREQ_W-1:0] tf,
			input logic [VOL_W-1:0] vol, input logic [LEN_W-1:0] len, input logic first);
		longint n;
		longint t_l;
		longint c_l;
		longint f;
		longint v_l;
		longint prod;
		longint res;
		int idx;
		t_l = tf;
		c_l = osc_freq;
		if (first) begin
			n = len;
			if (n < 1) begin
				n = 1;
			end
			if (n > MAX_LEN_CLAMP) begin
				n = MAX_LEN_CLAMP;
			end
			glide_step = (t_l != c_l) ? (t_l - c_l) / n : 0;
			glide_left = int'(n);
		end
		if (glide_left > 0) begin
			f = c_l + glide_step;
			if (f < 0) begin
				f = 0;
			end
			osc_freq = f[FREQ_W-1:0];
			glide_left--;
			if (glide_left == 0) begin
				osc_freq = tf;
			end
		end
		idx = int'(osc_phase[31:22]);
		v_l = vol;
		prod = v_l * longint'(sine_lut[idx]);
		res = (prod + 16384) >>> 15;
		if (res > 32767) begin
			res = 32767;
		end
		if (res < -32768) begin
			res = -32768;
		end
		osc_phase = osc_phase + freq_to_step(osc_freq, scale_now);
		return res[SMP_W-1:0];
	endfunction

	function automatic logic [VOL_W-1:0] pick_volume();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'd32768;
			2: return 16'hFFFF;
			3, 4: return VOL_W'($urandom_range(0, 65535));
			default: return VOL_W'($urandom_range(16384, 32768));
		endcase
	endfunction

	task automatic send_tick(input logic [FREQ_W-1:0] tf, input logic [VOL_W-1:0] vol,
			input logic [LEN_W-1:0] len, input logic first, input logic fixed,
			input logic signed [SMP_W-1:0] want);
		logic signed [SMP_W-1:0] guess;
		if (!no_idle && tx_odds != 0 && $urandom_range(0, 9) < tx_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_freq <= tf;
		volume <= vol;
		block_len <= len;
		first_in_block <= first;
		do @(posedge clk); while (!in_ready);
		guess = next_sample(tf, vol, len, first);
		sample_q.push_back(fixed ? want : guess);
		ticks_sent++;
		if (first) begin
			blocks_started++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_now = value;
		scales_used++;
	endtask

	task automatic run_glide_phase(input int count);
		int sent;
		int len;
		logic [FREQ_W-1:0] tgt;
		logic [FREQ_W-1:0] tick_tgt;
		sent = 0;
		while (sent < count) begin
			if (sent % 64 == 0) begin
				tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end
			if ($urandom_range(0, 9) < 8) begin
				case ($urandom_range(0, 19))
					0: len = $urandom_range(65, 200);
					1, 2, 3, 4, 5: len = $urandom_range(13, 64);
					default: len = $urandom_range(1, 12);
				endcase
				if ($urandom_range(0, 7) == 0) begin
					tgt = osc_freq;
				end else begin
					tgt = FREQ_W'($urandom_range(3276800, 327680000));
				end
				send_tick(tgt, pick_volume(), LEN_W'(len), 1'b1, 1'b0, '0);
				for (int i = 1; i < len; i++) begin
					tick_tgt = ($urandom_range(0, 7) == 0) ?
						FREQ_W'($urandom_range(3276800, 327680000)) : tgt;
					send_tick(tick_tgt, pick_volume(), LEN_W'($urandom_range(0, 8191)),
						1'b0, 1'b0, '0);
				end
				sent += len;
			end else begin
				send_tick(FREQ_W'($urandom), VOL_W'($urandom), LEN_W'($urandom),
					1'($urandom), 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Timed out with %0d samples still expected.", sample_q.size());
		$display("tb_sine_oscillator_with_glide NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		logic signed [SMP_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (sample_q.size() == 0) begin
				if (mismatches < 10) begin
					$display("Unexpected sample %0d at %0t.", sample_out, $realtime);
				end
				mismatches++;
			end else begin
				want = sample_q.pop_front();
				samples_checked++;
				if (sample_out !== want) begin
					if (mismatches < 10) begin
						$display("Sample %0d mismatch: expected %0d, got %0d.",
							samples_checked, want, sample_out);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		int stall_left;
		int cycles;
		stall_left = 0;
		cycles = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles % 150 == 0) begin
				rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end
			if (long_hold) begin
				long_hold = 1'b0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!no_idle && rx_odds != 0 && $urandom_range(0, 9) < rx_odds) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 12);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [SCALE_W-1:0] scales [N_PHASES];
		int guard;
		arst_n = 1'b0;
		in_valid = 1'b0;
		target_freq = '0;
		volume = '0;
		block_len = '0;
		first_in_block = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		ticks_sent = 0;
		blocks_started = 0;
		samples_checked = 0;
		scales_used = 1;
		tx_odds = 3;
		rx_odds = 3;
		no_idle = 1'b0;
		long_hold = 1'b0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			sine_lut[k] = sine_point(k);
		end
		osc_phase = '0;
		osc_freq = FREQ_RESET;
		glide_step = 0;
		glide_left = 0;
		scale_now = SCALE_RESET;
		scales[0] = SCALE_MIN;
		scales[1] = SCALE_MAX;
		scales[2] = SCALE_W'({$urandom, $urandom});
		scales[3] = SCALE_ONES;
		scales[4] = SCALE_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_tick(dir_rows[i].target, dir_rows[i].vol, dir_rows[i].len,
				dir_rows[i].first, dir_rows[i].fixed, dir_rows[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			no_idle = (p == N_PHASES - 1);
			write_scale(scales[p]);
			if (p == 1) begin
				long_hold = 1'b1;
			end
			run_glide_phase(TICKS_PER_PHASE);
		end

		in_valid <= 1'b0;
		guard = 0;
		while (sample_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d ticks in %0d glide blocks over %0d step-scale settings.",
			ticks_sent, blocks_started, scales_used);
		$display("Checked %0d samples: %0d mismatches, %0d still expected.",
			samples_checked, mismatches, sample_q.size());
		if (mismatches == 0 && sample_q.size() == 0) begin
			$display("tb_sine_oscillator_with_glide OK");
		end else begin
			$display("tb_sine_oscillator_with_glide NOT OK");
		end
		$finish;
	end

endmodule
